// ===== hdl/bhaskara_sine_cosine_q16_macros.svh =====
// Assertion helpers for the one asserting file, bhaskara_sine_cosine_q16.sv.
`ifndef BHASKARA_SINE_COSINE_Q16_MACROS_SVH
`define BHASKARA_SINE_COSINE_Q16_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define BSC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Whenever ante holds, cons must hold in the same cycle.
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// ===== hdl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int FULL_TURN    = 3600;
  localparam int HALF_TURN    = 1800;
  localparam int QUARTER_TURN = 900;
  localparam int BHASKARA_K   = 4050000;

  // Smallest multiple of a full turn that lifts any 32-bit angle above zero.
  localparam longint TURN_BIAS =
    longint'(FULL_TURN) * ((longint'(1) <<< 31) / FULL_TURN + 1);

  // Residues of 2^16 and 2^12 modulo a full turn, used to fold high bits down.
  localparam int FOLD16 = (1 << 16) % FULL_TURN;
  localparam int FOLD12 = (1 << 12) % FULL_TURN;

  // After the last fold the value stays below 19472, so at most ten half turns.
  localparam int HALF_STEPS = 10;

  localparam int D_W   = 11;  // reduced angle, below one half turn
  localparam int P_W   = 20;  // d*(1800-d), at most 810000
  localparam int DEN_W = 22;  // 4050000-p, and the divider remainder

  typedef struct packed {
    logic [D_W-1:0] d;
    logic           neg;
  } angle_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
  } frac_t;

endpackage

// ===== hdl/bsc_if.sv =====
interface bsc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] angle_x10;

  modport source (output valid, kind, angle_x10, input ready);
  modport sink (input valid, kind, angle_x10, output ready);
endinterface

interface bsc_out_if #(
  parameter int W = 18
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

// ===== hdl/bsc_reduce.sv =====
module bsc_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_ready,
  input  logic               kind,
  input  logic signed [31:0] angle_x10,
  output logic               dst_valid,
  input  logic               dst_ready,
  output bsc_pkg::angle_t    angle
);

  localparam int STAGES = 6;

  logic [STAGES:1]   vld;
  logic [STAGES+1:1] rdy;

  logic [32:0] u;
  logic [26:0] v;
  logic [20:0] w;
  logic [16:0] x;
  logic [14:0] y;

  logic [33:0]     sum;
  logic [3:0]      k_sel;
  logic [14:0]     base;
  bsc_pkg::angle_t angle_next;

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    rdy[STAGES+1] = dst_ready;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign src_ready = rdy[1];
  assign dst_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= src_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Bias to a non-negative value with the same residue; the sum never wraps.
  assign sum = {{2{angle_x10[31]}}, angle_x10}
             + (kind ? 34'(bsc_pkg::QUARTER_TURN) : 34'd0)
             + 34'(bsc_pkg::TURN_BIAS);

  // Fold the last value by whole half turns; an odd count flips the sign.
  always_comb begin
    k_sel = '0;
    for (int k = 1; k <= bsc_pkg::HALF_STEPS; k++) begin
      if (y >= 15'(k * bsc_pkg::HALF_TURN)) k_sel = 4'(k);
    end
    base = 15'(k_sel) * 15'(bsc_pkg::HALF_TURN);
    angle_next.d   = bsc_pkg::D_W'(y - base);
    angle_next.neg = k_sel[0];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) u <= sum[32:0];
    if (rdy[2]) v <= 27'(u[32:16]) * 27'(bsc_pkg::FOLD16) + 27'(u[15:0]);
    if (rdy[3]) w <= 21'(v[26:16]) * 21'(bsc_pkg::FOLD16) + 21'(v[15:0]);
    if (rdy[4]) x <= 17'(w[20:16]) * 17'(bsc_pkg::FOLD16) + 17'(w[15:0]);
    if (rdy[5]) y <= 15'(x[16:12]) * 15'(bsc_pkg::FOLD12) + 15'(x[11:0]);
    if (rdy[6]) angle <= angle_next;
  end

endmodule

// ===== hdl/bsc_poly.sv =====
module bsc_poly (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_ready,
  input  bsc_pkg::angle_t angle,
  output logic            dst_valid,
  input  logic            dst_ready,
  output bsc_pkg::frac_t  frac
);

  logic [2:1] vld;
  logic [3:1] rdy;

  logic [bsc_pkg::P_W-1:0] p;
  logic                    p_neg;
  logic [bsc_pkg::D_W-1:0] comp;

  assign rdy[3] = dst_ready;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];

  assign src_ready = rdy[1];
  assign dst_valid = vld[2];

  assign comp = bsc_pkg::D_W'(bsc_pkg::HALF_TURN) - angle.d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= src_valid;
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // The divider starts from 2p, the numerator 4p*2^F with its F+1 zero
  // low bits taken off.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p     <= bsc_pkg::P_W'(angle.d) * bsc_pkg::P_W'(comp);
      p_neg <= angle.neg;
    end
    if (rdy[2]) begin
      frac.den <= bsc_pkg::DEN_W'(bsc_pkg::BHASKARA_K) - bsc_pkg::DEN_W'(p);
      frac.rem <= bsc_pkg::DEN_W'({p, 1'b0});
      frac.neg <= p_neg;
    end
  end

endmodule

// ===== hdl/bsc_div.sv =====
module bsc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  bsc_pkg::frac_t       frac,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output logic [FRAC_BITS:0]   mag,
  output logic                 neg
);

  localparam int Q  = FRAC_BITS + 1;
  localparam int DW = bsc_pkg::DEN_W;

  logic [Q:1]   vld;
  logic [Q+1:1] rdy;

  logic [DW-1:0] rem [1:Q];
  logic [DW-1:0] den [1:Q];
  logic [Q-1:0]  quo [1:Q];
  logic          sgn [1:Q];

  logic [DW-1:0] in_rem [1:Q];
  logic [DW-1:0] in_den [1:Q];
  logic [Q-1:0]  in_quo [1:Q];
  logic          in_sgn [1:Q];
  logic [DW-1:0] nx_rem [1:Q];
  logic [Q-1:0]  nx_quo [1:Q];

  always_comb begin
    rdy[Q+1] = dst_ready;
    for (int k = Q; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign src_ready = rdy[1];
  assign dst_valid = vld[Q];
  assign mag       = quo[Q];
  assign neg       = sgn[Q];

  always_comb begin
    in_rem[1] = frac.rem;
    in_den[1] = frac.den;
    in_quo[1] = '0;
    in_sgn[1] = frac.neg;
    for (int k = 2; k <= Q; k++) begin
      in_rem[k] = rem[k-1];
      in_den[k] = den[k-1];
      in_quo[k] = quo[k-1];
      in_sgn[k] = sgn[k-1];
    end
  end

  // One quotient bit per stage: shift the remainder, subtract if it fits.
  always_comb begin
    for (int k = 1; k <= Q; k++) begin
      if ({in_rem[k], 1'b0} >= {1'b0, in_den[k]}) begin
        nx_rem[k] = DW'({in_rem[k], 1'b0} - {1'b0, in_den[k]});
        nx_quo[k] = {in_quo[k][Q-2:0], 1'b1};
      end else begin
        nx_rem[k] = {in_rem[k][DW-2:0], 1'b0};
        nx_quo[k] = {in_quo[k][Q-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= src_valid;
      for (int k = 2; k <= Q; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= Q; k++) begin
      if (rdy[k]) begin
        rem[k] <= nx_rem[k];
        den[k] <= in_den[k];
        quo[k] <= nx_quo[k];
        sgn[k] <= in_sgn[k];
      end
    end
  end

endmodule

// ===== hdl/bhaskara_sine_cosine_q16.sv =====
// Sine / cosine of an angle in tenths of a degree, Bhaskara I approximation,
// result in signed fixed point with FRAC_BITS fraction bits.
//
// arg (sink): kind (0 sine, 1 cosine) and a signed 32-bit angle_x10. A
//   transaction completes on a clock edge with valid and ready both high.
// result (source): value, FRAC_BITS+2 bits signed, from -1.0 to +1.0.
//
// Throughput: one transaction per cycle, sustained while result is ready.
// Between an arg transaction and result valid, six stages reduce the
// angle into a half turn, two form p and 4050000-p, the restoring
// divider retires one quotient bit per stage (FRAC_BITS+1 stages), and
// one output register applies the sign.
//
// Each stage holds its own valid bit and loads when empty or when its
// successor moves, so a stall at result backs up stage by stage: bubbles
// are squeezed out and nothing is dropped or repeated. Outside reset,
// arg.ready falls only once every stage is full and result is stalled.
//
// Reset (rst, synchronous) clears every valid bit and the in-flight count;
// arg.ready is held low while rst is high. Data registers are not reset.
`include "bhaskara_sine_cosine_q16_macros.svh"

module bhaskara_sine_cosine_q16 #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  bsc_in_if.sink   arg,
  bsc_out_if.source result
);

  localparam int OW    = FRAC_BITS + 2;
  localparam int DEPTH = FRAC_BITS + 10;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ONE_Q = 1 << FRAC_BITS;

  // Reduction to a half turn.
  logic            red_ready;
  logic            red_valid;
  logic            poly_ready;
  bsc_pkg::angle_t red_angle;

  // p and the denominator.
  logic            poly_valid;
  logic            div_ready;
  bsc_pkg::frac_t  poly_frac;

  // Divider.
  logic               div_valid;
  logic [FRAC_BITS:0] div_mag;
  logic               div_neg;

  // Output register.
  logic          ovld;
  logic [OW-1:0] oval;
  logic          out_ready;
  logic [OW-1:0] mag_ext;

  // Transactions in flight, for the checks below.
  logic [CW-1:0] inflight;
  logic          acc_in;
  logic          acc_out;

  assign arg.ready = red_ready && !rst;

  bsc_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .src_valid (arg.valid),
    .src_ready (red_ready),
    .kind      (arg.kind),
    .angle_x10 (arg.angle_x10),
    .dst_valid (red_valid),
    .dst_ready (poly_ready),
    .angle     (red_angle)
  );

  bsc_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .src_valid (red_valid),
    .src_ready (poly_ready),
    .angle     (red_angle),
    .dst_valid (poly_valid),
    .dst_ready (div_ready),
    .frac      (poly_frac)
  );

  bsc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .src_valid (poly_valid),
    .src_ready (div_ready),
    .frac      (poly_frac),
    .dst_valid (div_valid),
    .dst_ready (out_ready),
    .mag       (div_mag),
    .neg       (div_neg)
  );

  // Output register: advance when empty or when the receiver takes the value.
  assign out_ready = !ovld || result.ready;
  assign mag_ext   = {1'b0, div_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (out_ready) begin
      ovld <= div_valid;
    end
  end

  // Negate on the lower half turn; a zero magnitude stays zero.
  always_ff @(posedge clk) begin
    if (out_ready) oval <= div_neg ? OW'(0) - mag_ext : mag_ext;
  end

  assign result.valid = ovld;
  assign result.value = oval;

  assign acc_in  = arg.valid && arg.ready;
  assign acc_out = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(acc_in) - CW'(acc_out);
    end
  end

  `BSC_ASSERT_ALWAYS(a_value_range, clk, rst, !result.valid || ($signed(result.value) <= ONE_Q && $signed(result.value) >= -ONE_Q))
  `BSC_ASSERT_IMPL(a_no_phantom, clk, rst, result.valid, inflight != '0)
  `BSC_ASSERT_ALWAYS(a_depth_bound, clk, rst, inflight <= CW'(DEPTH))
  `BSC_ASSERT_IMPL(a_full_stall, clk, rst, inflight == CW'(DEPTH) && !result.ready, !arg.ready)

endmodule
